[hdl/negative_cycle_detector_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the negative cycle detector
// Clocked, reset-qualified property forms used by the detector module.
// ----------------------------------------------------------------------------
`ifndef NEGATIVE_CYCLE_DETECTOR_ASSERT_SVH
`define NEGATIVE_CYCLE_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/ncd_pkg.sv]
// ----------------------------------------------------------------------------
// ncd_pkg
// Sizes, the stored edge format and the controller states of the detector.
// ----------------------------------------------------------------------------
package ncd_pkg;

    localparam int MAX_NODES   = 128;
    localparam int MAX_EDGES   = 16384;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_BITS   = 7;
    localparam int NCFG_BITS   = 8;
    localparam int DIST_BITS   = 32;

    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);

    typedef struct packed {
        logic [NODE_BITS-1:0]          src;
        logic [NODE_BITS-1:0]          dst;
        logic signed [WEIGHT_BITS-1:0] weight;
    } t_edge;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_EREAD,
        S_DREAD,
        S_RELAX,
        S_PEND,
        S_OUT
    } t_state;

endpackage

[hdl/negative_cycle_detector.sv]
// ----------------------------------------------------------------------------
// negative_cycle_detector
// Stores directed weighted edges and, after the last one, runs Bellman-Ford
// passes from a virtual source to report whether a negative cycle exists.
//
//   Channel   Direction  Handshake          Payload
//   edge      in         i_valid / o_stall  src_node, dst_node, weight, last_edge
//   result    out        o_valid / i_stall  has_negative_cycle
//   config    in         i_cfg_we           node_count
//
// Edges are taken one per cycle while loading. A last edge starts a run that
// steps through each held edge in each pass: the edge memory read, then the
// distance memory read, then the update, over up to node_count passes (at
// least one, at most MAX_NODES). No request is taken while a run is active
// or its result waits. Reset is synchronous and clears the edge count.
// ----------------------------------------------------------------------------
`include "negative_cycle_detector_assert.svh"

module negative_cycle_detector (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ncd_pkg::NCFG_BITS-1:0]          i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [ncd_pkg::NODE_BITS-1:0]          i_src_node,
    input  logic [ncd_pkg::NODE_BITS-1:0]          i_dst_node,
    input  logic signed [ncd_pkg::WEIGHT_BITS-1:0] i_weight,
    input  logic                                   i_last_edge,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_has_negative_cycle
);
    import ncd_pkg::*;

    localparam logic signed [DIST_BITS:0] DIST_MIN = {2'b11, {(DIST_BITS-1){1'b0}}};

    t_state                 r_state, n_state;
    logic [NCFG_BITS-1:0]   r_node_count;
    logic [ECNT_W-1:0]      r_etotal, n_etotal;
    logic [ECNT_W-1:0]      r_eidx, n_eidx;
    logic [NCNT_W-1:0]      r_pass, n_pass;
    logic                   r_check, n_check;
    logic                   r_chg, n_chg;
    logic                   r_result, n_result;
    logic [MAX_NODES-1:0]   r_dvalid;

    t_edge                  r_emem [MAX_EDGES];
    logic [DIST_BITS-1:0]   r_dmem [MAX_NODES];
    t_edge                  r_ed;
    logic signed [DIST_BITS-1:0] r_du, r_dv;
    logic                   r_du_ok, r_dv_ok;

    logic [NCNT_W-1:0]      w_nact;
    logic                   w_ewe, w_ere, w_dwe, w_dclr;
    logic                   w_in_range, w_lower;
    logic signed [DIST_BITS-1:0] w_du, w_dv, w_sat;
    logic signed [DIST_BITS:0]   w_cand;
    t_edge                  w_new_edge;

    always_comb begin
        if (r_node_count == '0) begin
            w_nact = NCNT_W'(1);
        end else if (int'(r_node_count) > MAX_NODES) begin
            w_nact = NCNT_W'(MAX_NODES);
        end else begin
            w_nact = NCNT_W'(r_node_count);
        end
    end

    assign w_new_edge.src    = i_src_node;
    assign w_new_edge.dst    = i_dst_node;
    assign w_new_edge.weight = i_weight;

    assign w_du       = r_du_ok ? r_du : '0;
    assign w_dv       = r_dv_ok ? r_dv : '0;
    assign w_cand     = (DIST_BITS+1)'(w_du) + (DIST_BITS+1)'($signed(r_ed.weight));
    assign w_sat      = (w_cand < DIST_MIN) ? $signed(DIST_MIN[DIST_BITS-1:0])
                                            : $signed(w_cand[DIST_BITS-1:0]);
    assign w_in_range = (NCNT_W'(r_ed.src) < w_nact) && (NCNT_W'(r_ed.dst) < w_nact);
    assign w_lower    = w_in_range && (w_sat < w_dv);

    assign o_stall              = (r_state != S_LOAD);
    assign o_valid              = (r_state == S_OUT);
    assign o_has_negative_cycle = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NCFG_BITS'(1);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_etotal <= '0;
            r_eidx   <= '0;
            r_pass   <= '0;
            r_check  <= 1'b0;
            r_chg    <= 1'b0;
            r_result <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_etotal <= n_etotal;
            r_eidx   <= n_eidx;
            r_pass   <= n_pass;
            r_check  <= n_check;
            r_chg    <= n_chg;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
        end else if (w_dclr) begin
            r_dvalid <= '0;
        end else if (w_dwe) begin
            r_dvalid[r_ed.dst[NODE_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ewe) begin
            r_emem[r_etotal[EDGE_AW-1:0]] <= w_new_edge;
        end
        if (w_ere) begin
            r_ed <= r_emem[r_eidx[EDGE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dwe) begin
            r_dmem[r_ed.dst[NODE_AW-1:0]] <= w_sat;
        end
        if (r_state == S_DREAD) begin
            r_du    <= $signed(r_dmem[r_ed.src[NODE_AW-1:0]]);
            r_dv    <= $signed(r_dmem[r_ed.dst[NODE_AW-1:0]]);
            r_du_ok <= r_dvalid[r_ed.src[NODE_AW-1:0]];
            r_dv_ok <= r_dvalid[r_ed.dst[NODE_AW-1:0]];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_etotal = r_etotal;
        n_eidx   = r_eidx;
        n_pass   = r_pass;
        n_check  = r_check;
        n_chg    = r_chg;
        n_result = r_result;
        w_ewe    = 1'b0;
        w_ere    = 1'b0;
        w_dwe    = 1'b0;
        w_dclr   = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_etotal < ECNT_W'(MAX_EDGES)) begin
                        w_ewe    = 1'b1;
                        n_etotal = r_etotal + ECNT_W'(1);
                    end
                    if (i_last_edge) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                w_dclr  = 1'b1;
                n_pass  = '0;
                n_eidx  = '0;
                n_chg   = 1'b0;
                n_check = !(w_nact > NCNT_W'(1));
                n_state = S_EREAD;
            end
            S_EREAD: begin
                if (r_eidx == r_etotal) begin
                    n_state = S_PEND;
                end else begin
                    w_ere   = 1'b1;
                    n_state = S_DREAD;
                end
            end
            S_DREAD: begin
                n_state = S_RELAX;
            end
            S_RELAX: begin
                if (w_lower) begin
                    w_dwe = 1'b1;
                    n_chg = 1'b1;
                end
                n_eidx  = r_eidx + ECNT_W'(1);
                n_state = S_EREAD;
            end
            S_PEND: begin
                n_eidx = '0;
                n_chg  = 1'b0;
                if (r_check) begin
                    n_result = r_chg;
                    n_state  = S_OUT;
                end else begin
                    n_pass = r_pass + NCNT_W'(1);
                    if (!r_chg) begin
                        n_result = 1'b0;
                        n_state  = S_OUT;
                    end else if ((NCNT_W+1)'(r_pass) + (NCNT_W+1)'(2)
                                 < (NCNT_W+1)'(w_nact)) begin
                        n_state = S_EREAD;
                    end else begin
                        n_check = 1'b1;
                        n_state = S_EREAD;
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_etotal = '0;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `NCD_ASSERT_IMP(a_edge_read_held, w_ere, r_eidx < r_etotal, "Edge read beyond the held edges.")
    `NCD_ASSERT_IMP(a_edge_total_max, 1'b1, r_etotal <= ECNT_W'(MAX_EDGES), "Edge count overflow.")
    `NCD_ASSERT_IMP(a_pass_bound, (r_state == S_EREAD) && !r_check, (NCNT_W+1)'(r_pass) + (NCNT_W+1)'(1) < (NCNT_W+1)'(w_nact), "Ordinary pass beyond node count.")
    `NCD_ASSERT_NXT(a_run_clears, o_valid && !i_stall, (r_etotal == '0) && (r_state == S_LOAD), "Edge count not cleared after a run.")

endmodule
